@@ rtl/alpha64_mask_blend_defines.svh @@
// assertion helpers for the alpha-64 mask blend
`ifndef ALPHA64_MASK_BLEND_DEFINES_SVH
`define ALPHA64_MASK_BLEND_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define A64MB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("a64mb check failed");

// next-cycle implication, masked while reset is low
`define A64MB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("a64mb check failed");

`endif

@@ rtl/a64mb_pkg.sv @@
`default_nettype none
package a64mb_pkg;

    // mask values and blend scaling
    localparam int MASK_W      = 7;
    localparam int MASK_MAX    = 64;
    localparam int BLEND_SHIFT = 6;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_W = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_H = 1'd1;

    // mask subsampling mode
    typedef struct packed {
        logic sub_w;
        logic sub_h;
    } mode_t;

    typedef logic [MASK_W-1:0] mask_t;

endpackage
`default_nettype wire

@@ rtl/alpha64_mask_blend.sv @@
// alpha-64 mask blend, one output pixel per beat
// input channel s_*: two source samples, four mask values (0..64, larger values
// clamp to 64) and an end-of-block flag; output channel m_*: the blended pixel
// and the flag passed through
// configuration: cfg_we writes cfg_data into register cfg_index
// (0: sub_w, 1: sub_h); write only while no beat is in flight
// effective weight: mask_a, the rounded mean of mask_a/mask_b with one
// direction subsampled, or the rounded mean of all four with both
// latency: 2 cycles from input beat to output valid (input register, then
// weight and blend logic into the output register)
// throughput: one beat per cycle, set by the two-stage register pipeline
// stall: when m_ready is low the output register holds; the input register
// still loads while the output stage is empty or draining, so at most two
// beats sit inside; s_ready drops only when both stages are full and stalled
// reset: aresetn low for a cycle empties both stages and clears sub_w/sub_h
`default_nettype none
`include "alpha64_mask_blend_defines.svh"
module alpha64_mask_blend #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [a64mb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [a64mb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [PIXEL_BITS-1:0]             s_first_sample,
    input  logic [PIXEL_BITS-1:0]             s_second_sample,
    input  a64mb_pkg::mask_t                  s_mask_a,
    input  a64mb_pkg::mask_t                  s_mask_b,
    input  a64mb_pkg::mask_t                  s_mask_c,
    input  a64mb_pkg::mask_t                  s_mask_d,
    input  logic                              s_last_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [PIXEL_BITS-1:0]             m_blended,
    output logic                              m_last_out
);
    import a64mb_pkg::*;

    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [PIXEL_BITS-1:0]  s0_reg;
    logic [PIXEL_BITS-1:0]  s1_reg;
    mask_t                  ma_reg;
    mask_t                  mb_reg;
    mask_t                  mc_reg;
    mask_t                  md_reg;
    logic                   last_reg;
    logic [PIXEL_BITS-1:0]  blended_reg;
    logic                   last_out_reg;
    mask_t                  weight;
    logic [PIXEL_BITS-1:0]  blended_comb;
    logic                   out_load;
    logic                   in_load;

    // configuration register decode
    always_comb begin
        mode_next = mode_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_SUB_W: mode_next.sub_w = cfg_data[0];
                REG_SUB_H: mode_next.sub_h = cfg_data[0];
                default:   mode_next = mode_reg;
            endcase
        end
    end

    // pipeline advance
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_load || (in_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !m_ready);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (in_load) begin
            s0_reg   <= s_first_sample;
            s1_reg   <= s_second_sample;
            ma_reg   <= s_mask_a;
            mb_reg   <= s_mask_b;
            mc_reg   <= s_mask_c;
            md_reg   <= s_mask_d;
            last_reg <= s_last_in;
        end
    end

    // effective weight
    a64mb_weight u_weight (
        .mode   (mode_reg),
        .mask_a (ma_reg),
        .mask_b (mb_reg),
        .mask_c (mc_reg),
        .mask_d (md_reg),
        .weight (weight)
    );

    // weighted blend
    a64mb_blend #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_blend (
        .weight        (weight),
        .first_sample  (s0_reg),
        .second_sample (s1_reg),
        .blended       (blended_comb)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            blended_reg  <= blended_comb;
            last_out_reg <= last_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_blended  = blended_reg;
    assign m_last_out = last_out_reg;

    // checks
    `A64MB_ASSERT_IMPL(a_weight_range, aclk, aresetn, in_valid_reg, weight <= mask_t'(MASK_MAX))
    `A64MB_ASSERT_NEXT(a_stage_moves, aclk, aresetn, in_valid_reg && out_load, out_valid_reg)
    `A64MB_ASSERT_IMPL(a_empty_ready, aclk, aresetn, !in_valid_reg && !out_valid_reg, s_ready)

endmodule
`default_nettype wire

@@ rtl/a64mb_weight.sv @@
`default_nettype none
module a64mb_weight (
    input  a64mb_pkg::mode_t mode,
    input  a64mb_pkg::mask_t mask_a,
    input  a64mb_pkg::mask_t mask_b,
    input  a64mb_pkg::mask_t mask_c,
    input  a64mb_pkg::mask_t mask_d,
    output a64mb_pkg::mask_t weight
);
    import a64mb_pkg::*;

    localparam mask_t MAX_M = mask_t'(MASK_MAX);

    mask_t a_sat;
    mask_t b_sat;
    mask_t c_sat;
    mask_t d_sat;
    logic [MASK_W+1:0] sum4;
    logic [MASK_W:0]   sum2;

    // clamp each mask to 64
    assign a_sat = (mask_a > MAX_M) ? MAX_M : mask_a;
    assign b_sat = (mask_b > MAX_M) ? MAX_M : mask_b;
    assign c_sat = (mask_c > MAX_M) ? MAX_M : mask_c;
    assign d_sat = (mask_d > MAX_M) ? MAX_M : mask_d;

    // rounded averages of four and of two masks
    assign sum4 = {2'b00, a_sat} + {2'b00, b_sat} + {2'b00, c_sat} + {2'b00, d_sat}
                + (MASK_W+2)'(2);
    assign sum2 = {1'b0, a_sat} + {1'b0, b_sat} + (MASK_W+1)'(1);

    // select by subsampling mode
    always_comb begin
        if (mode.sub_w && mode.sub_h) begin
            weight = sum4[MASK_W+1:2];
        end else if (mode.sub_w || mode.sub_h) begin
            weight = sum2[MASK_W:1];
        end else begin
            weight = a_sat;
        end
    end

endmodule
`default_nettype wire

@@ rtl/a64mb_blend.sv @@
`default_nettype none
module a64mb_blend #(
    parameter int PIXEL_BITS = 12
) (
    input  a64mb_pkg::mask_t       weight,
    input  logic [PIXEL_BITS-1:0]  first_sample,
    input  logic [PIXEL_BITS-1:0]  second_sample,
    output logic [PIXEL_BITS-1:0]  blended
);
    import a64mb_pkg::*;

    localparam int ACC_W = PIXEL_BITS + MASK_W;

    mask_t             inv_weight;
    logic [ACC_W-1:0]  prod0;
    logic [ACC_W-1:0]  prod1;
    logic [ACC_W-1:0]  acc;

    // complementary weight, weights always total 64
    assign inv_weight = mask_t'(MASK_MAX) - weight;

    // weighted sum with half-step rounding
    assign prod0 = ACC_W'(weight) * ACC_W'(first_sample);
    assign prod1 = ACC_W'(inv_weight) * ACC_W'(second_sample);
    assign acc   = prod0 + prod1 + ACC_W'(1 << (BLEND_SHIFT - 1));

    assign blended = acc[BLEND_SHIFT +: PIXEL_BITS];

endmodule
`default_nettype wire
